>>> rtl/core/stack_machine_core_assert.svh
// Assertion macros for the stack machine core.
// Expects clk and rst in the scope of the including module.
`ifndef STACK_MACHINE_CORE_ASSERT_SVH
`define STACK_MACHINE_CORE_ASSERT_SVH

// Same-cycle implication
`define SMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/smc_pkg.sv
// Shared types and constants for the stack machine core.
// No dependencies; imported by smc_div, smc_dp, smc_ctrl and the top level.
package smc_pkg;

  localparam int WORD_W        = 32;
  localparam int LOAD_ADDR_W   = 8;
  localparam int STACK_DEPTH   = 256;
  localparam int PROGRAM_DEPTH = 256;
  localparam int PA_W          = $clog2(PROGRAM_DEPTH);
  localparam int IP_W          = PA_W + 1;
  localparam int SA_W          = $clog2(STACK_DEPTH);
  localparam int SP_W          = SA_W + 1;
  localparam int NUM_GREGS     = 4;
  localparam int GR_W          = $clog2(NUM_GREGS);
  localparam int REG_IP        = 4;
  localparam int REG_SP        = 5;
  localparam int DIV_CNT_W     = $clog2(WORD_W) + 1;

  typedef enum logic [1:0] {
    OPER_LOAD    = 2'd0,
    OPER_STEP    = 2'd1,
    OPER_RESTART = 2'd2
  } oper_t;

  typedef enum logic [3:0] {
    OPC_HLT = 4'd0,
    OPC_PSH = 4'd1,
    OPC_POP = 4'd2,
    OPC_ADD = 4'd3,
    OPC_SUB = 4'd4,
    OPC_MUL = 4'd5,
    OPC_DIV = 4'd6,
    OPC_SET = 4'd7,
    OPC_MOV = 4'd8,
    OPC_JMP = 4'd9,
    OPC_JZ  = 4'd10,
    OPC_PRT = 4'd11,
    OPC_UNK = 4'd15
  } opc_t;

  localparam int NUM_OPCODES = 12;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HLT     = 3'd1,
    ST_OVER    = 3'd2,
    ST_UNDER   = 3'd3,
    ST_DIVZ    = 3'd4,
    ST_BADREG  = 3'd5,
    ST_BADADDR = 3'd6
  } stat_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PRT  = 2'd1,
    KIND_POP  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_HALT,
    CMD_FETCH,
    CMD_CAP_OP,
    CMD_CAP_W1,
    CMD_CAP_W2,
    CMD_RD_TOP,
    CMD_CAP_A_RD_B,
    CMD_CAP_B,
    CMD_PUSH,
    CMD_POP_OUT,
    CMD_ALU_START,
    CMD_ALU_WB,
    CMD_WRITE_REG,
    CMD_JUMP,
    CMD_JZ,
    CMD_EMIT
  } cmd_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FETCH_OP,
    S_CAP_OP,
    S_DECODE,
    S_FETCH_W1,
    S_CAP_W1,
    S_FETCH_W2,
    S_CAP_W2,
    S_EXEC,
    S_JZ,
    S_POP,
    S_RD_B,
    S_CAP_B,
    S_ARITH,
    S_DIV_WAIT,
    S_WB,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    cmd_op_t op;
    stat_t   code;
  } dp_cmd_t;

  typedef struct packed {
    logic running;
    logic ip_oob;
    logic sp_empty;
    logic sp_lt2;
    logic sp_full;
    opc_t opc;
    logic reg_idx_bad;
    logic wr_bad;
    logic w1_ip_bad;
    logic a_zero;
    logic div_done;
    logic res_busy;
  } dp_stat_t;

endpackage

>>> rtl/core/smc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/smc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on smc_pkg.
module smc_div import smc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic              done,
  output logic [WORD_W-1:0] quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    q;
  logic [WORD_W-1:0]    d;
  logic                 neg;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      diff;
  logic                 ge;

  assign rem_sh = {rem, q[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, d};
  assign ge     = !diff[WORD_W];
  assign quo    = neg ? ('0 - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(WORD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num[WORD_W-1] ? ('0 - num) : num;
      d   <= den[WORD_W-1] ? ('0 - den) : den;
      neg <= num[WORD_W-1] ^ den[WORD_W-1];
    end else if (busy) begin
      rem <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      q   <= {q[WORD_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/smc_dp.sv
// Datapath: machine registers, program and stack stores, ALU, result register.
// Depends on smc_pkg, smc_ram and smc_div; driven by smc_ctrl commands.
module smc_dp import smc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [1:0]              operation,
  input  logic [LOAD_ADDR_W-1:0]  load_address,
  input  logic signed [WORD_W-1:0] load_data,
  input  logic                    res_ready,
  output logic                    res_valid,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic signed [WORD_W-1:0] out_value,
  output logic                    halted,
  output logic [2:0]              status
);

  logic [WORD_W-1:0]        gregs [NUM_GREGS];
  logic [IP_W-1:0]          ip;
  logic [SP_W-1:0]          sp;
  logic                     running;
  stat_t                    last_status;
  logic [PROGRAM_DEPTH-1:0] prog_vld;
  logic                     prog_vld_q;

  logic [WORD_W-1:0] prog_q;
  logic [WORD_W-1:0] stack_q;
  logic [WORD_W-1:0] fetch_word;
  logic [WORD_W-1:0] op_w;
  logic [WORD_W-1:0] w1;
  logic [WORD_W-1:0] w2;
  logic [WORD_W-1:0] a_val;
  logic [WORD_W-1:0] b_val;
  logic [WORD_W-1:0] alu_res;
  logic [WORD_W-1:0] value_r;
  kind_t             kind_r;

  logic [SP_W-1:0]   sp_inc;
  logic [SP_W-1:0]   sp_dec;
  opc_t              opc;
  logic [WORD_W-1:0] src_val;
  logic [WORD_W-1:0] mov_val;
  logic              load_hit;
  logic              prog_we;
  logic              stack_we;
  logic [SA_W-1:0]   stack_waddr;
  logic [WORD_W-1:0] stack_wdata;
  logic [SA_W-1:0]   stack_raddr;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;
  logic              res_busy;

  assign sp_inc     = sp + 1'b1;
  assign sp_dec     = sp - 1'b1;
  assign fetch_word = prog_vld_q ? prog_q : '0;
  assign res_busy   = res_valid && !res_ready;

  always_comb begin
    if (op_w < WORD_W'(NUM_OPCODES)) begin
      opc = opc_t'(op_w[3:0]);
    end else begin
      opc = OPC_UNK;
    end
  end

  // Register read for MOV; the source index is known to be in range here
  always_comb begin
    if (w2 < WORD_W'(NUM_GREGS)) begin
      mov_val = gregs[w2[GR_W-1:0]];
    end else if (w2 == WORD_W'(REG_IP)) begin
      mov_val = WORD_W'(ip);
    end else begin
      mov_val = {{(WORD_W-SP_W){sp[SP_W-1]}}, sp};
    end
  end

  assign src_val = (opc == OPC_MOV) ? mov_val : w2;

  always_comb begin
    stat             = '0;
    stat.running     = running;
    stat.ip_oob      = WORD_W'(ip) >= WORD_W'(PROGRAM_DEPTH);
    stat.sp_empty    = sp[SP_W-1];
    stat.sp_lt2      = sp[SP_W-1] || (sp == '0);
    stat.sp_full     = sp == SP_W'(STACK_DEPTH - 1);
    stat.opc         = opc;
    stat.reg_idx_bad = (w1 > WORD_W'(REG_SP)) ||
                       ((opc == OPC_MOV) && (w2 > WORD_W'(REG_SP)));
    if (w1 == WORD_W'(REG_IP)) begin
      stat.wr_bad = src_val >= WORD_W'(PROGRAM_DEPTH);
    end else if (w1 == WORD_W'(REG_SP)) begin
      stat.wr_bad = !((src_val == '1) || (src_val < WORD_W'(STACK_DEPTH)));
    end else begin
      stat.wr_bad = 1'b0;
    end
    stat.w1_ip_bad   = w1 >= WORD_W'(PROGRAM_DEPTH);
    stat.a_zero      = a_val == '0;
    stat.div_done    = div_done;
    stat.res_busy    = res_busy;
  end

  // Program store
  assign load_hit = 32'(load_address) < PROGRAM_DEPTH;
  assign prog_we  = (cmd.op == CMD_ACCEPT) && (operation == OPER_LOAD) && load_hit;

  smc_ram #(.WIDTH(WORD_W), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (PA_W'(load_address)),
    .wdata (load_data),
    .raddr (ip[PA_W-1:0]),
    .rdata (prog_q)
  );

  // Stack store
  assign stack_we    = (cmd.op == CMD_PUSH) || (cmd.op == CMD_ALU_WB);
  assign stack_waddr = (cmd.op == CMD_PUSH) ? sp_inc[SA_W-1:0] : sp_dec[SA_W-1:0];
  assign stack_wdata = (cmd.op == CMD_PUSH) ? w1 :
                       ((opc == OPC_DIV) ? div_quo : alu_res);
  assign stack_raddr = (cmd.op == CMD_CAP_A_RD_B) ? sp_dec[SA_W-1:0] : sp[SA_W-1:0];

  smc_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_q)
  );

  assign div_start = (cmd.op == CMD_ALU_START) && (opc == OPC_DIV);

  smc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (b_val),
    .den   (a_val),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GREGS; i++) begin
        gregs[i] <= '0;
      end
      ip          <= '0;
      sp          <= '1;
      running     <= 1'b1;
      last_status <= ST_OK;
      prog_vld    <= '0;
      res_valid   <= 1'b0;
    end else begin
      // A new result may load in the cycle the old one leaves
      if (cmd.op == CMD_EMIT) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (cmd.op)
        CMD_ACCEPT: begin
          if (prog_we) begin
            prog_vld[PA_W'(load_address)] <= 1'b1;
          end
          if (operation == OPER_RESTART) begin
            ip          <= '0;
            sp          <= '1;
            running     <= 1'b1;
            last_status <= ST_OK;
          end
        end
        CMD_HALT: begin
          running     <= 1'b0;
          last_status <= cmd.code;
        end
        CMD_FETCH: begin
          ip <= ip + 1'b1;
        end
        CMD_PUSH: begin
          sp <= sp_inc;
        end
        CMD_POP_OUT: begin
          sp <= sp_dec;
        end
        CMD_ALU_WB: begin
          sp <= sp_dec;
        end
        CMD_WRITE_REG: begin
          if (w1 < WORD_W'(NUM_GREGS)) begin
            gregs[w1[GR_W-1:0]] <= src_val;
          end else if (w1 == WORD_W'(REG_IP)) begin
            ip <= src_val[IP_W-1:0];
          end else begin
            sp <= src_val[SP_W-1:0];
          end
        end
        CMD_JUMP: begin
          ip <= w1[IP_W-1:0];
        end
        CMD_JZ: begin
          sp <= sp_dec;
          if (stack_q == '0) begin
            if (stat.w1_ip_bad) begin
              running     <= 1'b0;
              last_status <= ST_BADADDR;
            end else begin
              ip <= w1[IP_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-item working registers and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_ACCEPT: begin
        kind_r  <= KIND_NONE;
        value_r <= '0;
      end
      CMD_FETCH:      prog_vld_q <= prog_vld[ip[PA_W-1:0]];
      CMD_CAP_OP:     op_w <= fetch_word;
      CMD_CAP_W1:     w1 <= fetch_word;
      CMD_CAP_W2:     w2 <= fetch_word;
      CMD_CAP_A_RD_B: a_val <= stack_q;
      CMD_CAP_B:      b_val <= stack_q;
      CMD_POP_OUT: begin
        kind_r  <= (opc == OPC_PRT) ? KIND_PRT : KIND_POP;
        value_r <= stack_q;
      end
      CMD_ALU_START: begin
        unique case (opc)
          OPC_ADD: alu_res <= b_val + a_val;
          OPC_SUB: alu_res <= b_val - a_val;
          OPC_MUL: alu_res <= b_val * a_val;
          default: alu_res <= '0;
        endcase
      end
      CMD_EMIT: begin
        out_valid <= kind_r != KIND_NONE;
        out_kind  <= kind_r;
        out_value <= value_r;
        halted    <= !running;
        status    <= last_status;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/smc_ctrl.sv
// Sequencer for the stack machine core: walks fetch, decode and execute steps.
// Depends on smc_pkg; issues commands to smc_dp and reads its status.
module smc_ctrl import smc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] operation,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = ((operation == OPER_STEP) && stat.running) ? S_FETCH_OP : S_DONE;
        end
      end
      S_FETCH_OP: state_next = stat.ip_oob ? S_DONE : S_CAP_OP;
      S_CAP_OP:   state_next = S_DECODE;
      S_DECODE: begin
        case (stat.opc) inside
          OPC_PSH, OPC_SET, OPC_MOV, OPC_JMP, OPC_JZ: state_next = S_FETCH_W1;
          OPC_POP, OPC_PRT: state_next = stat.sp_empty ? S_DONE : S_POP;
          OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: state_next = stat.sp_lt2 ? S_DONE : S_RD_B;
          default: state_next = S_DONE;
        endcase
      end
      S_FETCH_W1: state_next = stat.ip_oob ? S_DONE : S_CAP_W1;
      S_CAP_W1: begin
        state_next = ((stat.opc == OPC_SET) || (stat.opc == OPC_MOV)) ? S_FETCH_W2 : S_EXEC;
      end
      S_FETCH_W2: state_next = stat.ip_oob ? S_DONE : S_CAP_W2;
      S_CAP_W2:   state_next = S_EXEC;
      S_EXEC: begin
        state_next = ((stat.opc == OPC_JZ) && !stat.sp_empty) ? S_JZ : S_DONE;
      end
      S_JZ:  state_next = S_DONE;
      S_POP: state_next = S_DONE;
      S_RD_B: state_next = S_CAP_B;
      S_CAP_B: state_next = S_ARITH;
      S_ARITH: begin
        if (stat.opc == OPC_DIV) begin
          state_next = stat.a_zero ? S_DONE : S_DIV_WAIT;
        end else begin
          state_next = S_WB;
        end
      end
      S_DIV_WAIT: state_next = stat.div_done ? S_WB : S_DIV_WAIT;
      S_WB:   state_next = S_DONE;
      S_DONE: state_next = stat.res_busy ? S_DONE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '{op: CMD_NOP, code: ST_OK};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = CMD_ACCEPT;
        end
      end
      S_FETCH_OP, S_FETCH_W1, S_FETCH_W2: begin
        if (stat.ip_oob) begin
          cmd = '{op: CMD_HALT, code: ST_BADADDR};
        end else begin
          cmd.op = CMD_FETCH;
        end
      end
      S_CAP_OP: cmd.op = CMD_CAP_OP;
      S_DECODE: begin
        case (stat.opc) inside
          OPC_HLT: cmd = '{op: CMD_HALT, code: ST_HLT};
          OPC_POP, OPC_PRT: begin
            if (stat.sp_empty) begin
              cmd = '{op: CMD_HALT, code: ST_UNDER};
            end else begin
              cmd.op = CMD_RD_TOP;
            end
          end
          OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
            if (stat.sp_lt2) begin
              cmd = '{op: CMD_HALT, code: ST_UNDER};
            end else begin
              cmd.op = CMD_RD_TOP;
            end
          end
          default: cmd.op = CMD_NOP;
        endcase
      end
      S_CAP_W1: cmd.op = CMD_CAP_W1;
      S_CAP_W2: cmd.op = CMD_CAP_W2;
      S_EXEC: begin
        case (stat.opc) inside
          OPC_PSH: begin
            if (stat.sp_full) begin
              cmd = '{op: CMD_HALT, code: ST_OVER};
            end else begin
              cmd.op = CMD_PUSH;
            end
          end
          OPC_JMP: begin
            if (stat.w1_ip_bad) begin
              cmd = '{op: CMD_HALT, code: ST_BADADDR};
            end else begin
              cmd.op = CMD_JUMP;
            end
          end
          OPC_SET, OPC_MOV: begin
            if (stat.reg_idx_bad) begin
              cmd = '{op: CMD_HALT, code: ST_BADREG};
            end else if (stat.wr_bad) begin
              cmd = '{op: CMD_HALT, code: ST_BADADDR};
            end else begin
              cmd.op = CMD_WRITE_REG;
            end
          end
          OPC_JZ: begin
            if (stat.sp_empty) begin
              cmd = '{op: CMD_HALT, code: ST_UNDER};
            end else begin
              cmd.op = CMD_RD_TOP;
            end
          end
          default: cmd.op = CMD_NOP;
        endcase
      end
      S_JZ:   cmd.op = CMD_JZ;
      S_POP:  cmd.op = CMD_POP_OUT;
      S_RD_B: cmd.op = CMD_CAP_A_RD_B;
      S_CAP_B: cmd.op = CMD_CAP_B;
      S_ARITH: begin
        if ((stat.opc == OPC_DIV) && stat.a_zero) begin
          cmd = '{op: CMD_HALT, code: ST_DIVZ};
        end else begin
          cmd.op = CMD_ALU_START;
        end
      end
      S_DIV_WAIT: cmd.op = CMD_NOP;
      S_WB:   cmd.op = CMD_ALU_WB;
      S_DONE: begin
        if (!stat.res_busy) begin
          cmd.op = CMD_EMIT;
        end
      end
      default: cmd.op = CMD_NOP;
    endcase
  end

endmodule

>>> rtl/core/stack_machine_core.sv
// Stack machine core, top level.
// Depends on smc_pkg, smc_ctrl, smc_dp (with smc_ram, smc_div) and the assert macros.
//
// A 32-bit stack machine that handles one input transaction at a time and returns
// exactly one result transaction for each. A load transaction writes one program
// word, a restart transaction resets IP, SP, the running flag and the status, and a
// step transaction executes one instruction with its inline operands. Each program
// word and each stack operand costs a read of a memory with registered read data;
// DIV runs a divider that retires one quotient bit per cycle. The program store
// reads as zero (HLT) until written, tracked by one valid flop per word; no
// clearing pass is needed after reset. The finished result sits in an output
// register, so the sequencer returns to idle as soon as that register is free;
// out_value is zero whenever out_valid is low.
`include "stack_machine_core_assert.svh"

module stack_machine_core import smc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [LOAD_ADDR_W-1:0]   load_address,
  input  logic signed [WORD_W-1:0] load_data,
  // Result channel
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic                     out_valid,
  output logic [1:0]               out_kind,
  output logic signed [WORD_W-1:0] out_value,
  output logic                     halted,
  output logic [2:0]               status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: owns the input handshake and decides every datapath step
  smc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: machine state, both stores, ALU and divider, result register
  smc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .load_address (load_address),
    .load_data    (load_data),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .halted       (halted),
    .status       (status)
  );

  // An accepted transaction takes the sequencer out of idle, so in_ready drops after an acceptance
  `SMC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "input accepted twice in a row")

  // Any error or HLT status must come with the machine halted
  `SMC_ASSERT_NOW(a_status_halted, res_valid && (status != ST_OK), halted,
    "nonzero status while running")

  // Never push onto a full stack
  `SMC_ASSERT_NOW(a_no_overflow_push, cmd.op == CMD_PUSH, !stat.sp_full,
    "push issued on full stack")

  // A result is only loaded when the output register is free
  `SMC_ASSERT_NOW(a_emit_free, cmd.op == CMD_EMIT, !(res_valid && !res_ready),
    "result overwritten while pending")

endmodule
